// ===== hw/rtl/prik_pkg.sv =====
// ----------------------------------------------------------------------------
// prik_pkg
// Shared types, constants and arithmetic helpers for the 3-PSS inverse
// kinematics pipeline.
// ----------------------------------------------------------------------------
package prik_pkg;

  localparam int ANG_W = 25;
  localparam int CFG_W = 18;
  localparam int POS_W = 27;
  localparam int FRAC_BITS_DEF = 16;

  localparam int SC_LAT  = 18;
  localparam int MAT_LAT = 5;
  localparam int LEG_LAT = 37;

  typedef logic signed [31:0] trig_t;
  typedef logic signed [30:0] rail_t;

  typedef enum logic [1:0] {
    REG_RADIUS,
    REG_LINK,
    REG_POFF,
    REG_BOFF
  } cfg_reg_e;

  localparam logic [CFG_W-1:0] RADIUS_RST = 18'd23296;
  localparam logic [CFG_W-1:0] LINK_RST   = 18'd90624;
  localparam logic [CFG_W-1:0] POFF_RST   = 18'd12800;
  localparam logic [CFG_W-1:0] BOFF_RST   = 18'd12800;

  localparam trig_t Q30_ONE = 32'sd1073741824;
  localparam logic [29:0] SQ3_HALF = 30'd929887697;
  localparam logic [40:0] DEG_K = 41'd1228166276394;
  localparam logic [24:0] TURN = 25'd23592960;
  localparam logic [24:0] QUARTER_TURN = 25'd5898240;
  localparam logic [24:0] EIGHTH_TURN = 25'd2949120;

  localparam logic signed [63:0] POS_MAX = 64'sd67108863;
  localparam logic signed [63:0] POS_MIN = -64'sd67108864;

  localparam int SIN_DIV [5] = '{110, 72, 42, 20, 6};
  localparam int COS_DIV [5] = '{90, 56, 30, 12, 2};

  localparam rail_t RAIL_DIR [3][3] = '{
    '{-31'sd268435456,  31'sd464943848, -31'sd929887697},
    '{-31'sd268435456, -31'sd464943848, -31'sd929887697},
    '{ 31'sd536870912,  31'sd0,         -31'sd929887697}
  };

  // shift right by s, round half away from zero
  function automatic logic signed [63:0] rshr(input logic signed [63:0] x, input int s);
    logic [63:0] mag;
    logic [63:0] half;
    logic [63:0] r;
    if (s == 0) begin
      return x;
    end
    half = 64'd1 << (s - 1);
    mag  = x[63] ? 64'(-x) : 64'(x);
    r    = (mag + half) >> s;
    return x[63] ? -64'(r) : 64'(r);
  endfunction

  function automatic logic signed [63:0] mq(input trig_t a, input trig_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return rshr(p, 30);
  endfunction

  // truncating division by a constant, via reciprocal rm and shift sh
  function automatic trig_t div_rc(input trig_t p, input logic [63:0] rm, input int sh);
    logic [31:0] mag;
    logic [63:0] prod;
    logic [31:0] quo;
    mag  = p[31] ? 32'(-p) : 32'(p);
    prod = 64'(mag) * rm;
    quo  = 32'(prod >> sh);
    return p[31] ? -trig_t'(quo) : trig_t'(quo);
  endfunction

endpackage

// ===== hw/rtl/parallel_robot_inverse_kinematics.sv =====
// ----------------------------------------------------------------------------
// parallel_robot_inverse_kinematics
// 3-PSS platform inverse kinematics: Euler attitude in, three slider
// positions and a reach fault out.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: raise start with the three angles (Q16 degrees); it is taken
//   on any clock edge with busy low. busy never rises, so one pose can be
//   taken every cycle.
//   Result beat: done_o pulses for one cycle with the three leg positions
//   (Q FRAC_BITS mm) and unreachable_o; results come out in input order.
//   The receiver cannot stall, so nothing is held back.
//   Pipeline, in order: sine/cosine, rotation matrix and joint points, leg
//   incl. a 32-stage square root, then a registered output stage.
//   Throughput: one pose per cycle, set by the fully pipelined datapath.
//   Configuration: cfg_valid_i/cfg_index_i/cfg_data_i, always ready; write
//   only with the pipeline empty.
//   Reset: clears the valid pipeline and loads the default geometry; no
//   clearing pass.
// ----------------------------------------------------------------------------
module parallel_robot_inverse_kinematics import prik_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [ANG_W-1:0] angle_about_x_i,
  input  logic signed [ANG_W-1:0] angle_about_y_i,
  input  logic signed [ANG_W-1:0] angle_about_z_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  output logic                    done_o,
  output logic signed [POS_W-1:0] leg_position_1_o,
  output logic signed [POS_W-1:0] leg_position_2_o,
  output logic signed [POS_W-1:0] leg_position_3_o,
  output logic                    unreachable_o
);

  localparam int LAT = SC_LAT + MAT_LAT + LEG_LAT + 1;

  logic [CFG_W-1:0] rad_q, link_q, poff_q, boff_q;
  logic [27:0]      rs_q;
  logic [55:0]      ll_q;
  logic [LAT-1:0]   vld_q;

  logic signed [ANG_W-1:0] ang [3];
  trig_t sn [3], cs [3];

  trig_t cgcb_q, cgsb_q, sgsb_q, sgcb_q, sgca_q, cgca_q, sgsa_q, cgsa_q, cbsa_q, cbca_q;
  trig_t sa1_q, ca1_q, sb1_q;
  trig_t n1_q, n2_q, n3_q, n4_q;
  trig_t cgcb2_q, sgcb2_q, cbsa2_q, cbca2_q, sgca2_q, cgca2_q, sgsa2_q, cgsa2_q, sb2_q;
  logic signed [32:0] m_q [3][3];
  logic signed [29:0] pv [3][3];
  logic signed [29:0] r18s, rhs, rss, h18s;
  logic signed [63:0] pr_q [3][3][3];
  trig_t q_q [3][3];
  logic signed [POS_W-1:0] pos [3];
  logic neg [3];
  logic signed [POS_W-1:0] p1_q, p2_q, p3_q;
  logic unr_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q  <= RADIUS_RST;
      link_q <= LINK_RST;
      poff_q <= POFF_RST;
      boff_q <= BOFF_RST;
      vld_q  <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start && !busy};
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_RADIUS: rad_q  <= cfg_data_i;
          REG_LINK:   link_q <= cfg_data_i;
          REG_POFF:   poff_q <= cfg_data_i;
          REG_BOFF:   boff_q <= cfg_data_i;
          default:    rad_q  <= rad_q;
        endcase
      end
    end
  end

  // geometry terms that follow the registers
  always_ff @(posedge clk_i) begin
    rs_q <= 28'(rshr(64'({rad_q, 10'b0}) * 64'(SQ3_HALF), 30));
    ll_q <= 56'({link_q, 10'b0}) * 56'({link_q, 10'b0});
  end

  assign r18s = 30'({rad_q, 10'b0});
  assign rhs  = 30'({rad_q, 9'b0});
  assign rss  = 30'(rs_q);
  assign h18s = 30'({poff_q, 10'b0});

  always_comb begin
    pv[0][0] = -r18s;
    pv[0][1] = 30'sd0;
    pv[0][2] = h18s;
    pv[1][0] = rhs;
    pv[1][1] = -rss;
    pv[1][2] = h18s;
    pv[2][0] = rhs;
    pv[2][1] = rss;
    pv[2][2] = h18s;
  end

  assign ang[0] = angle_about_x_i;
  assign ang[1] = angle_about_y_i;
  assign ang[2] = angle_about_z_i;

  for (genvar a = 0; a < 3; a++) begin : g_trig
    prik_sincos u_sincos (
      .clk_i   (clk_i),
      .angle_i (ang[a]),
      .sin_o   (sn[a]),
      .cos_o   (cs[a])
    );
  end

  // rotation matrix Rz*Ry*Rx
  always_ff @(posedge clk_i) begin
    cgcb_q <= 32'(mq(cs[2], cs[1]));
    cgsb_q <= 32'(mq(cs[2], sn[1]));
    sgsb_q <= 32'(mq(sn[2], sn[1]));
    sgcb_q <= 32'(mq(sn[2], cs[1]));
    sgca_q <= 32'(mq(sn[2], cs[0]));
    cgca_q <= 32'(mq(cs[2], cs[0]));
    sgsa_q <= 32'(mq(sn[2], sn[0]));
    cgsa_q <= 32'(mq(cs[2], sn[0]));
    cbsa_q <= 32'(mq(cs[1], sn[0]));
    cbca_q <= 32'(mq(cs[1], cs[0]));
    sa1_q  <= sn[0];
    ca1_q  <= cs[0];
    sb1_q  <= sn[1];

    n1_q    <= 32'(mq(cgsb_q, sa1_q));
    n2_q    <= 32'(mq(cgsb_q, ca1_q));
    n3_q    <= 32'(mq(sgsb_q, sa1_q));
    n4_q    <= 32'(mq(sgsb_q, ca1_q));
    cgcb2_q <= cgcb_q;
    sgcb2_q <= sgcb_q;
    cbsa2_q <= cbsa_q;
    cbca2_q <= cbca_q;
    sgca2_q <= sgca_q;
    cgca2_q <= cgca_q;
    sgsa2_q <= sgsa_q;
    cgsa2_q <= cgsa_q;
    sb2_q   <= sb1_q;

    m_q[0][0] <= 33'(cgcb2_q);
    m_q[0][1] <= 33'(n1_q) - 33'(sgca2_q);
    m_q[0][2] <= 33'(n2_q) + 33'(sgsa2_q);
    m_q[1][0] <= 33'(sgcb2_q);
    m_q[1][1] <= 33'(n3_q) + 33'(cgca2_q);
    m_q[1][2] <= 33'(n4_q) - 33'(cgsa2_q);
    m_q[2][0] <= -33'(sb2_q);
    m_q[2][1] <= 33'(cbsa2_q);
    m_q[2][2] <= 33'(cbca2_q);
  end

  // rotated joint points
  for (genvar k = 0; k < 3; k++) begin : g_joint
    for (genvar i = 0; i < 3; i++) begin : g_row
      always_ff @(posedge clk_i) begin
        for (int j = 0; j < 3; j++) begin
          pr_q[k][i][j] <= 64'(m_q[i][j]) * 64'(pv[k][j]);
        end
      end
      if (i == 2) begin : g_lift
        always_ff @(posedge clk_i) begin
          q_q[k][i] <= 32'(rshr(pr_q[k][i][0] + pr_q[k][i][1] + pr_q[k][i][2], 30))
                     + 32'({boff_q, 10'b0});
        end
      end else begin : g_flat
        always_ff @(posedge clk_i) begin
          q_q[k][i] <= 32'(rshr(pr_q[k][i][0] + pr_q[k][i][1] + pr_q[k][i][2], 30));
        end
      end
    end

    prik_leg #(
      .FRAC_BITS (FRAC_BITS)
    ) u_leg (
      .clk_i  (clk_i),
      .q_i    (q_q[k]),
      .rail_i (RAIL_DIR[k]),
      .ll_i   (ll_q),
      .pos_o  (pos[k]),
      .neg_o  (neg[k])
    );
  end

  always_ff @(posedge clk_i) begin
    unr_q <= neg[0] || neg[1] || neg[2];
    if (neg[0] || neg[1] || neg[2]) begin
      p1_q <= '0;
      p2_q <= '0;
      p3_q <= '0;
    end else begin
      p1_q <= pos[0];
      p2_q <= pos[1];
      p3_q <= pos[2];
    end
  end

  assign done_o           = vld_q[LAT-1];
  assign leg_position_1_o = p1_q;
  assign leg_position_2_o = p2_q;
  assign leg_position_3_o = p3_q;
  assign unreachable_o    = unr_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("accepted beat did not complete after fixed latency");

  a_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("result beat without a matching input beat");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && unreachable_o) |->
      (leg_position_1_o == '0 && leg_position_2_o == '0 && leg_position_3_o == '0))
    else $error("unreachable result with nonzero positions");

endmodule

// ===== hw/rtl/prik_sincos.sv =====
// ----------------------------------------------------------------------------
// prik_sincos
// Pipelined sine and cosine of a Q16 degree angle: octant reduction, degree
// to radian scaling and Horner-form Taylor series, one stage per product.
// ----------------------------------------------------------------------------
module prik_sincos import prik_pkg::*; (
  input  logic                    clk_i,
  input  logic signed [ANG_W-1:0] angle_i,
  output trig_t                   sin_o,
  output trig_t                   cos_o
);

  localparam logic [24:0] KT1 = EIGHTH_TURN;
  localparam logic [24:0] KT2 = 25'(QUARTER_TURN + EIGHTH_TURN);
  localparam logic [24:0] KT3 = 25'(2 * QUARTER_TURN + EIGHTH_TURN);
  localparam logic [24:0] KT4 = 25'(3 * QUARTER_TURN + EIGHTH_TURN);
  localparam logic signed [44:0] K_LO = 45'(DEG_K[19:0]);
  localparam logic signed [44:0] K_HI = 45'(DEG_K[40:20]);

  logic [24:0]        t1_q, t2_q;
  logic [2:0]         k2_q;
  logic signed [22:0] u3_q;
  logic [1:0]         qd3_q, qd4_q, qd5_q, qf_q;
  logic signed [44:0] plo_q, phi_q;
  trig_t              x5_q;
  trig_t              cx_q  [11];
  trig_t              cx2_q [9];
  logic [1:0]         cq_q  [11];
  trig_t              sp_q [5], cp_q [5];
  trig_t              hs_q [1:5], hc_q [1:5];
  trig_t              sf_q, cf_q, sn_q, cs_q;
  logic [24:0]        base;
  logic signed [63:0] xfull;

  always_comb begin
    unique case (k2_q)
      3'd0:    base = 25'd0;
      3'd1:    base = QUARTER_TURN;
      3'd2:    base = 25'(2 * QUARTER_TURN);
      3'd3:    base = 25'(3 * QUARTER_TURN);
      3'd4:    base = TURN;
      default: base = 25'd0;
    endcase
    xfull = (64'(phi_q) <<< 20) + 64'(plo_q);
  end

  always_ff @(posedge clk_i) begin
    t1_q  <= angle_i[ANG_W-1] ? 25'(26'(angle_i) + 26'(TURN)) : 25'(angle_i);
    t2_q  <= t1_q;
    k2_q  <= 3'(t1_q >= KT1) + 3'(t1_q >= KT2) + 3'(t1_q >= KT3) + 3'(t1_q >= KT4);
    u3_q  <= 23'(26'(t2_q) - 26'(base));
    qd3_q <= k2_q[1:0];
    plo_q <= 45'(u3_q) * K_LO;
    phi_q <= 45'(u3_q) * K_HI;
    qd4_q <= qd3_q;
    x5_q  <= 32'(rshr(xfull, 32));
    qd5_q <= qd4_q;
    cx_q[0]  <= x5_q;
    cx2_q[0] <= 32'(mq(x5_q, x5_q));
    cq_q[0]  <= qd5_q;
  end

  for (genvar n = 1; n <= 10; n++) begin : g_carry
    always_ff @(posedge clk_i) begin
      cx_q[n] <= cx_q[n-1];
      cq_q[n] <= cq_q[n-1];
    end
    if (n <= 8) begin : g_x2
      always_ff @(posedge clk_i) begin
        cx2_q[n] <= cx2_q[n-1];
      end
    end
  end

  for (genvar j = 0; j < 5; j++) begin : g_horner
    localparam int DS = SIN_DIV[j];
    localparam int DC = COS_DIV[j];
    localparam int SHS = 31 + $clog2(DS);
    localparam int SHC = 31 + $clog2(DC);
    localparam logic [63:0] RMS = ((64'd1 << SHS) + 64'(DS) - 64'd1) / DS;
    localparam logic [63:0] RMC = ((64'd1 << SHC) + 64'(DC) - 64'd1) / DC;

    if (j == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        sp_q[j] <= 32'(mq(cx2_q[2*j], Q30_ONE));
        cp_q[j] <= 32'(mq(cx2_q[2*j], Q30_ONE));
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        sp_q[j] <= 32'(mq(cx2_q[2*j], hs_q[j]));
        cp_q[j] <= 32'(mq(cx2_q[2*j], hc_q[j]));
      end
    end

    always_ff @(posedge clk_i) begin
      hs_q[j+1] <= Q30_ONE - div_rc(sp_q[j], RMS, SHS);
      hc_q[j+1] <= Q30_ONE - div_rc(cp_q[j], RMC, SHC);
    end
  end

  always_ff @(posedge clk_i) begin
    sf_q <= 32'(mq(cx_q[10], hs_q[5]));
    cf_q <= hc_q[5];
    qf_q <= cq_q[10];
    unique case (qf_q)
      2'd0: begin
        sn_q <= sf_q;
        cs_q <= cf_q;
      end
      2'd1: begin
        sn_q <= cf_q;
        cs_q <= -sf_q;
      end
      2'd2: begin
        sn_q <= -sf_q;
        cs_q <= -cf_q;
      end
      default: begin
        sn_q <= -cf_q;
        cs_q <= sf_q;
      end
    endcase
  end

  assign sin_o = sn_q;
  assign cos_o = cs_q;

endmodule

// ===== hw/rtl/prik_leg.sv =====
// ----------------------------------------------------------------------------
// prik_leg
// One leg: rail projection, discriminant, pipelined square root (one result
// bit per stage) and output scaling with saturation.
// ----------------------------------------------------------------------------
module prik_leg import prik_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  trig_t                   q_i    [3],
  input  rail_t                   rail_i [3],
  input  logic [55:0]             ll_i,
  output logic signed [POS_W-1:0] pos_o,
  output logic                    neg_o
);

  localparam int SHR = (FRAC_BITS <= 18) ? 18 - FRAC_BITS : 0;
  localparam int SHL = (FRAC_BITS > 18) ? FRAC_BITS - 18 : 0;

  logic signed [63:0] rp_q [3];
  logic signed [63:0] sq_q [3];
  logic signed [33:0] b2_q, b3_q;
  logic signed [65:0] ss2_q, ss3_q;
  logic signed [67:0] bb_q;
  logic signed [69:0] dsc;
  logic [63:0]        sx_q [32];
  logic signed [33:0] sb_q [33];
  logic               sn_q [33];
  logic [33:0]        rm_q [1:31];
  logic [31:0]        rt_q [1:32];
  logic signed [63:0] dsum, dsh;
  logic signed [POS_W-1:0] pos_q;
  logic               neg_q;

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      rp_q[j] <= 64'(rail_i[j]) * 64'(q_i[j]);
      sq_q[j] <= 64'(q_i[j]) * 64'(q_i[j]);
    end
    b2_q  <= 34'(rshr(rp_q[0] + rp_q[1] + rp_q[2], 30));
    ss2_q <= 66'(sq_q[0]) + 66'(sq_q[1]) + 66'(sq_q[2]);
    bb_q  <= 68'(b2_q) * 68'(b2_q);
    b3_q  <= b2_q;
    ss3_q <= ss2_q;
  end

  assign dsc = 70'(bb_q) - 70'(ss3_q) + 70'(ll_i);

  always_ff @(posedge clk_i) begin
    sx_q[0] <= dsc[69] ? 64'd0 : dsc[63:0];
    sn_q[0] <= dsc[69];
    sb_q[0] <= b3_q;
  end

  for (genvar n = 1; n <= 32; n++) begin : g_sqrt
    localparam int BI = 32 - n;
    logic [35:0] cur, trial, diff;
    logic [31:0] root_in;
    logic [33:0] rem_in;
    logic        take;

    if (n == 1) begin : g_first
      assign rem_in  = 34'd0;
      assign root_in = 32'd0;
    end else begin : g_next
      assign rem_in  = rm_q[n-1];
      assign root_in = rt_q[n-1];
    end

    assign cur   = {rem_in, sx_q[n-1][2*BI+1 -: 2]};
    assign trial = 36'({root_in, 2'b01});
    assign take  = cur >= trial;
    assign diff  = cur - trial;

    always_ff @(posedge clk_i) begin
      rt_q[n] <= {root_in[30:0], take};
      sb_q[n] <= sb_q[n-1];
      sn_q[n] <= sn_q[n-1];
    end
    if (n < 32) begin : g_rem
      always_ff @(posedge clk_i) begin
        rm_q[n] <= take ? diff[33:0] : cur[33:0];
        sx_q[n] <= sx_q[n-1];
      end
    end
  end

  always_comb begin
    dsum = 64'(sb_q[32]) + 64'(rt_q[32]);
    dsh  = rshr(dsum, SHR) <<< SHL;
  end

  always_ff @(posedge clk_i) begin
    if (dsh > POS_MAX) begin
      pos_q <= POS_W'(POS_MAX);
    end else if (dsh < POS_MIN) begin
      pos_q <= POS_W'(POS_MIN);
    end else begin
      pos_q <= POS_W'(dsh);
    end
    neg_q <= sn_q[32];
  end

  assign pos_o = pos_q;
  assign neg_o = neg_q;

endmodule

// ===== test/parallel_robot_inverse_kinematics_tb.sv =====
// ----------------------------------------------------------------------------
// parallel_robot_inverse_kinematics_tb
// Drives Euler attitudes into the 3-PSS kinematics pipeline under several
// geometry settings, predicts each leg position and reach fault in a local
// fixed-point model, and checks every done_o beat in order.
// ----------------------------------------------------------------------------
module parallel_robot_inverse_kinematics_tb;
  import prik_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int LATENCY = 61;
  localparam int CYCLE_LIMIT = 400000;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint HALF_SQ3 = 64'sd929887697;
  localparam longint QUART_SQ3 = 64'sd464943848;
  localparam longint DEG2RAD = 64'sd1228166276394;
  localparam longint FULL_TURN = 64'sd23592960;
  localparam longint QTR_TURN = 64'sd5898240;
  localparam longint OCT_TURN = 64'sd2949120;
  localparam longint ANG_MAX = 64'sd11796480;

  typedef struct packed {
    logic signed [POS_W-1:0] leg1;
    logic signed [POS_W-1:0] leg2;
    logic signed [POS_W-1:0] leg3;
    logic                    unreach;
  } leg_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [ANG_W-1:0] angle_about_x_i = '0;
  logic signed [ANG_W-1:0] angle_about_y_i = '0;
  logic signed [ANG_W-1:0] angle_about_z_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic done_o;
  logic signed [POS_W-1:0] leg_position_1_o, leg_position_2_o, leg_position_3_o;
  logic unreachable_o;

  parallel_robot_inverse_kinematics #(.FRAC_BITS(FRAC)) u_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  leg_result_t pending_legs[$];
  int errors = 0;
  int cycles = 0;
  bit burst = 1'b0;
  logic [CFG_W-1:0] geo_radius = RADIUS_RST;
  logic [CFG_W-1:0] geo_link = LINK_RST;
  logic [CFG_W-1:0] geo_poff = POFF_RST;
  logic [CFG_W-1:0] geo_boff = BOFF_RST;

  function automatic longint round_shift(longint x, int s);
    longint half;
    if (s == 0) return x;
    half = 64'sd1 <<< (s - 1);
    if (x >= 0) return (x + half) >>> s;
    return -((-x + half) >>> s);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return round_shift(a * b, 30);
  endfunction

  function automatic longint int_root(longint v);
    logic [63:0] rem, root, bit_w;
    rem = v;
    root = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > rem && bit_w != 0) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (rem >= root + bit_w) begin
        rem = rem - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return longint'(root);
  endfunction

  task automatic sin_cos(input logic signed [ANG_W-1:0] ang, output longint sn,
                         output longint cs);
    longint t, k, x, x2, s, c;
    int sdiv[5], cdiv[5];
    sdiv = '{110, 72, 42, 20, 6};
    cdiv = '{90, 56, 30, 12, 2};
    t = longint'(ang);
    while (t < 0) t += FULL_TURN;
    while (t >= FULL_TURN) t -= FULL_TURN;
    k = (t + OCT_TURN) / QTR_TURN;
    x = round_shift((t - k * QTR_TURN) * DEG2RAD, 32);
    x2 = qmul(x, x);
    s = ONE_Q30;
    c = ONE_Q30;
    for (int i = 0; i < 5; i++) begin
      s = ONE_Q30 - qmul(x2, s) / sdiv[i];
      c = ONE_Q30 - qmul(x2, c) / cdiv[i];
    end
    s = qmul(x, s);
    case (k & 3)
      0: begin sn = s; cs = c; end
      1: begin sn = c; cs = -s; end
      2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endtask

  task automatic predict_legs(input logic signed [ANG_W-1:0] ax, ay, az,
                              output leg_result_t res);
    longint sa, ca, sb, cb, sg, cg, r18, h18, hb18, l18, rs, b, dsc, d;
    longint m[3][3], p[3][3], q[3], pos[3], rail[3][3];
    bit fault;
    rail = '{'{-64'sd268435456, QUART_SQ3, -HALF_SQ3},
             '{-64'sd268435456, -QUART_SQ3, -HALF_SQ3},
             '{64'sd536870912, 64'sd0, -HALF_SQ3}};
    fault = 1'b0;
    sin_cos(ax, sa, ca);
    sin_cos(ay, sb, cb);
    sin_cos(az, sg, cg);
    m[0][0] = qmul(cg, cb);
    m[0][1] = qmul(qmul(cg, sb), sa) - qmul(sg, ca);
    m[0][2] = qmul(qmul(cg, sb), ca) + qmul(sg, sa);
    m[1][0] = qmul(sg, cb);
    m[1][1] = qmul(qmul(sg, sb), sa) + qmul(cg, ca);
    m[1][2] = qmul(qmul(sg, sb), ca) - qmul(cg, sa);
    m[2][0] = -sb;
    m[2][1] = qmul(cb, sa);
    m[2][2] = qmul(cb, ca);
    r18 = longint'(geo_radius) << 10;
    h18 = longint'(geo_poff) << 10;
    hb18 = longint'(geo_boff) << 10;
    l18 = longint'(geo_link) << 10;
    rs = round_shift(r18 * HALF_SQ3, 30);
    p = '{'{-r18, 64'sd0, h18}, '{r18 / 2, -rs, h18}, '{r18 / 2, rs, h18}};
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++)
        q[i] = round_shift(m[i][0] * p[k][0] + m[i][1] * p[k][1] + m[i][2] * p[k][2], 30);
      q[2] += hb18;
      b = round_shift(rail[k][0] * q[0] + rail[k][1] * q[1] + rail[k][2] * q[2], 30);
      dsc = b * b - (q[0] * q[0] + q[1] * q[1] + q[2] * q[2]) + l18 * l18;
      if (dsc < 0) begin
        fault = 1'b1;
        pos[k] = 0;
      end else begin
        d = b + int_root(dsc);
        d = (FRAC <= 18) ? round_shift(d, 18 - FRAC) : d * (64'sd1 <<< (FRAC - 18));
        if (d > 64'sd67108863) d = 64'sd67108863;
        if (d < -64'sd67108864) d = -64'sd67108864;
        pos[k] = d;
      end
    end
    res.leg1 = fault ? '0 : pos[0][POS_W-1:0];
    res.leg2 = fault ? '0 : pos[1][POS_W-1:0];
    res.leg3 = fault ? '0 : pos[2][POS_W-1:0];
    res.unreach = fault;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_legs.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        leg_result_t w;
        w = pending_legs.pop_front();
        if (leg_position_1_o !== w.leg1) report_mismatch("leg1", leg_position_1_o, w.leg1);
        if (leg_position_2_o !== w.leg2) report_mismatch("leg2", leg_position_2_o, w.leg2);
        if (leg_position_3_o !== w.leg3) report_mismatch("leg3", leg_position_3_o, w.leg3);
        if (unreachable_o !== w.unreach) report_mismatch("unreach", unreachable_o, w.unreach);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("parallel_robot_inverse_kinematics_tb failed");
      $finish;
    end
  end

  // called at a rising edge; leaves at the edge that took the beat
  task automatic send_pose(input logic signed [ANG_W-1:0] ax, ay, az);
    leg_result_t res;
    bit taken;
    int gap;
    gap = burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    predict_legs(ax, ay, az, res);
    start <= 1'b1;
    angle_about_x_i <= ax;
    angle_about_y_i <= ay;
    angle_about_z_i <= az;
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
    pending_legs.push_back(res);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_legs.size() != 0) @(posedge clk_i);
  endtask

  // leaves valid high at the taking edge; the caller drops it after the last beat
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    case (idx)
      REG_RADIUS: geo_radius = val;
      REG_LINK:   geo_link = val;
      REG_POFF:   geo_poff = val;
      default:    geo_boff = val;
    endcase
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] r, l, ph, hb);
    drain();
    write_reg(REG_RADIUS, r);
    write_reg(REG_LINK, l);
    write_reg(REG_POFF, ph);
    write_reg(REG_BOFF, hb);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [ANG_W-1:0] rand_angle();
    if ($urandom_range(0, 9) == 0) return ANG_W'($urandom);
    return ANG_W'(longint'($urandom_range(0, 2 * ANG_MAX)) - ANG_MAX);
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      send_pose(rand_angle(), rand_angle(), rand_angle());
    end
    burst = 1'b0;
  endtask

  task automatic test_directed;
    logic signed [ANG_W-1:0] edges[12];
    edges = '{25'sd0, 25'sd11796480, -25'sd11796480, 25'sd5898240, -25'sd5898240,
              25'sd2949120, -25'sd2949120, 25'sd2949119, 25'sd16777215, -25'sd16777216,
              25'sd1, -25'sd1};
    foreach (edges[i]) send_pose(edges[i], edges[(i + 3) % 12], edges[(i + 7) % 12]);
    send_pose(edges[1], edges[1], edges[1]);
    send_pose(edges[8], edges[9], edges[2]);
  endtask

  task automatic test_unreachable;
    set_geometry(18'd23296, 18'd0, 18'd12800, 18'd12800);
    run_random(20);
    set_geometry(18'd262143, 18'd20000, 18'd262143, 18'd0);
    run_random(40);
  endtask

  task automatic test_saturation;
    set_geometry(18'd262143, 18'd262143, 18'd262143, 18'd262143);
    run_random(60);
    set_geometry(18'd0, 18'd0, 18'd0, 18'd0);
    run_random(40);
  endtask

  task automatic test_geometry_sweep;
    for (int ph = 0; ph < 8; ph++) begin
      set_geometry(CFG_W'($urandom), CFG_W'($urandom_range(60000, 262143)),
                   CFG_W'($urandom), CFG_W'($urandom));
      run_random(80);
    end
  endtask

  task automatic test_default_geometry;
    set_geometry(RADIUS_RST, LINK_RST, POFF_RST, BOFF_RST);
    run_random(300);
    drain();
    @(posedge clk_i);
    run_random(300);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_default_geometry();
    test_unreachable();
    test_saturation();
    test_geometry_sweep();
    drain();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0 && pending_legs.size() == 0) begin
      $display("parallel_robot_inverse_kinematics_tb passed");
    end else begin
      $display("parallel_robot_inverse_kinematics_tb failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/prik_pkg.sv
hw/rtl/prik_sincos.sv
hw/rtl/prik_leg.sv
hw/rtl/parallel_robot_inverse_kinematics.sv
test/parallel_robot_inverse_kinematics_tb.sv
